/* rtl/mqfb_pkg.sv */
// ----------------------------------------------------------------------------
// mqfb_pkg: shared types and constants for the multi-queue FIFO bank
// Sizes of the queue bank, item field widths, the command passed from the
// front end to the back end, and the state encodings of both ends.
// ----------------------------------------------------------------------------
`default_nettype none

package mqfb_pkg;

  // Bank geometry
  localparam int MAX_QUEUES  = 16;
  localparam int QUEUE_DEPTH = 256;
  localparam int QW  = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int ECW = $clog2(MAX_QUEUES + 1);
  localparam int AW  = QW + PW;

  // Field widths
  localparam int CFG_W     = 5;
  localparam int CFG_RESET = 16;
  localparam int CAT_W     = 16;
  localparam int ID_W      = 31;
  localparam int S_TDATA_W = ((CAT_W + ID_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((ID_W + 7) / 8) * 8;

  // Modulo unit: category bits retired per cycle
  localparam int MOD_BITS  = 4;
  localparam int MOD_STEPS = CAT_W / MOD_BITS;
  localparam int MSW       = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FAW        = $clog2(FIFO_DEPTH);

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [QW-1:0]   queue;
    logic [ID_W-1:0] post_id;
  } cmd_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } fr_state_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } bk_state_t;

  // Clamp the configured queue count to 1..MAX_QUEUES
  function automatic logic [ECW-1:0] eff_count(input logic [CFG_W-1:0] c);
    if (c == '0) begin
      return ECW'(1);
    end else if (int'(c) > MAX_QUEUES) begin
      return ECW'(MAX_QUEUES);
    end else begin
      return ECW'(c);
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/mqfb_front.sv */
// ----------------------------------------------------------------------------
// mqfb_front: request intake and queue selection
// Accepts one request, reduces its category modulo the queue count with a
// restoring remainder unit, and hands a command to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mqfb_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire mqfb_pkg::kind_t               in_kind,
  input  wire logic [mqfb_pkg::CAT_W-1:0]    in_category,
  input  wire logic [mqfb_pkg::ID_W-1:0]     in_post_id,
  input  wire logic [mqfb_pkg::CFG_W-1:0]    queue_count,
  output logic                               cmd_valid,
  input  wire logic                          cmd_ready,
  output mqfb_pkg::cmd_t                     cmd
);
  import mqfb_pkg::*;

  fr_state_t            state, state_next;
  kind_t                kind_r;
  logic [ID_W-1:0]      id_r;
  logic [CAT_W-1:0]     cat_r, cat_next;
  logic [ECW-1:0]       rem, rem_next;
  logic [ECW-1:0]       eff;
  logic [MSW-1:0]       step;
  logic [ECW:0]         trial;
  logic [ECW-1:0]       r_w;
  logic [CAT_W-1:0]     sh_w;
  logic                 accept;
  logic                 last_step;

  assign accept    = in_valid && in_ready;
  assign last_step = (step == MSW'(MOD_STEPS - 1));

  // Retire MOD_BITS category bits: shift in, compare, subtract
  always_comb begin
    r_w   = rem;
    sh_w  = cat_r;
    trial = '0;
    for (int i = 0; i < MOD_BITS; i++) begin
      trial = {r_w, sh_w[CAT_W-1]};
      sh_w  = sh_w << 1;
      if (trial >= {1'b0, eff}) begin
        trial = trial - {1'b0, eff};
      end
      r_w = trial[ECW-1:0];
    end
    rem_next = r_w;
    cat_next = sh_w;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: if (in_valid) state_next = FR_DIV;
      FR_DIV:  if (last_step) state_next = FR_PUSH;
      FR_PUSH: if (cmd_ready) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd_valid     = 1'b0;
    case (state)
      FR_IDLE: in_ready  = 1'b1;
      FR_PUSH: cmd_valid = 1'b1;
      default: ;
    endcase
    cmd.kind    = kind_r;
    cmd.queue   = rem[QW-1:0];
    cmd.post_id = id_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        step <= '0;
      end else if (state == FR_DIV) begin
        step <= step + 1'b1;
      end
    end
  end

  // Payload registers: load on accept, advance during division
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      id_r   <= in_post_id;
      cat_r  <= in_category;
      rem    <= '0;
      eff    <= eff_count(queue_count);
    end else if (state == FR_DIV) begin
      cat_r <= cat_next;
      rem   <= rem_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/mqfb_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// mqfb_cmd_fifo: command queue between front and back
// A short register FIFO that lets the front end and the back end stall
// independently of each other.
// ----------------------------------------------------------------------------
`default_nettype none

module mqfb_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mqfb_pkg::cmd_t in_cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mqfb_pkg::cmd_t      out_cmd
);
  import mqfb_pkg::*;

  cmd_t           slots [FIFO_DEPTH];
  logic [FAW-1:0] wr_ptr, rd_ptr;
  logic [FAW:0]   count;
  logic           push, pop;

  assign in_ready  = (count != (FAW+1)'(FIFO_DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FAW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FAW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

/* rtl/mqfb_back.sv */
// ----------------------------------------------------------------------------
// mqfb_back: queue engine
// Holds the per-queue head, tail and fill count plus the entry memory,
// executes one command at a time and drives the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module mqfb_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  output logic                             cmd_ready,
  input  wire mqfb_pkg::cmd_t              cmd,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [mqfb_pkg::ID_W-1:0]        out_value,
  output logic                             out_empty,
  output logic                             out_full
);
  import mqfb_pkg::*;

  bk_state_t        state, state_next;
  logic [PW-1:0]    head [MAX_QUEUES];
  logic [PW-1:0]    tail [MAX_QUEUES];
  logic [CW-1:0]    fill [MAX_QUEUES];
  logic [ID_W-1:0]  store [2**AW];
  logic [ID_W-1:0]  rd_data;
  logic [PW-1:0]    head_q, tail_q;
  logic [CW-1:0]    fill_q;
  logic             take, hit_full, hit_empty, do_enq, do_deq;
  logic [AW-1:0]    wr_addr, rd_addr;

  // Look up the addressed queue
  assign head_q    = head[cmd.queue];
  assign tail_q    = tail[cmd.queue];
  assign fill_q    = fill[cmd.queue];
  assign hit_full  = (fill_q == CW'(QUEUE_DEPTH));
  assign hit_empty = (fill_q == '0);
  assign wr_addr   = {cmd.queue, tail_q};
  assign rd_addr   = {cmd.queue, head_q};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (do_deq) state_next = BK_READ;
      BK_READ: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Outputs: take a command only with the result register free
  always_comb begin
    cmd_ready = 1'b0;
    case (state)
      BK_IDLE: cmd_ready = !out_valid;
      default: ;
    endcase
    take   = cmd_valid && cmd_ready;
    do_enq = take && (cmd.kind == KIND_ENQ) && !hit_full;
    do_deq = take && (cmd.kind == KIND_DEQ) && !hit_empty;
  end

  // Pointer and fill count updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      for (int i = 0; i < MAX_QUEUES; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (do_enq) begin
        tail[cmd.queue] <= (tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
        fill[cmd.queue] <= fill_q + 1'b1;
      end
      if (do_deq) begin
        head[cmd.queue] <= (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
        fill[cmd.queue] <= fill_q - 1'b1;
      end
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_enq) begin
      store[wr_addr] <= cmd.post_id;
    end
    if (do_deq) begin
      rd_data <= store[rd_addr];
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && !do_deq) begin
      out_valid <= 1'b1;
    end else if (state == BK_READ) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take && !do_deq) begin
      out_value <= '0;
      out_empty <= (cmd.kind == KIND_DEQ) && hit_empty;
      out_full  <= (cmd.kind == KIND_ENQ) && hit_full;
    end else if (state == BK_READ) begin
      out_value <= rd_data;
      out_empty <= 1'b0;
      out_full  <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/multi_queue_fifo_bank.sv */
// ----------------------------------------------------------------------------
// multi_queue_fifo_bank: bank of independent FIFO queues of post identifiers
// Enqueue and dequeue requests addressed by category; one result per item.
// ----------------------------------------------------------------------------
// Each request selects queue (category mod queue_count), with queue_count
// clamped to 1..16, and returns one result: the dequeued identifier, an empty
// flag for a dequeue on an empty queue, or a full flag for a dropped enqueue
// (each queue holds 256 identifiers). The front end takes one item at a
// time: it accepts it, runs the remainder unit that retires 4 category bits
// per cycle, then hands the command over before it takes the next. A short
// command queue decouples it from the queue engine, which registers the
// result of an enqueue or an empty dequeue directly; for a dequeue that reads
// the entry memory it registers the read data, then the result. queue_count
// must only be written while no item is in flight.
`default_nettype none

module multi_queue_fifo_bank (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // [15:0] category, [46:16] post_id, [47] zero
  input  wire logic [mqfb_pkg::S_TDATA_W-1:0]    s_tdata,
  // [0] kind
  input  wire logic                              s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [30:0] value, [31] zero
  output logic [mqfb_pkg::M_TDATA_W-1:0]         m_tdata,
  // [0] was_empty, [1] was_full
  output logic [1:0]                             m_tuser,
  input  wire logic                              cfg_we,
  input  wire logic [mqfb_pkg::CFG_W-1:0]        cfg_wdata
);
  import mqfb_pkg::*;

  logic [CFG_W-1:0] queue_count;
  cmd_t             f_cmd, b_cmd;
  logic             f_valid, f_ready, b_valid, b_ready;
  logic [ID_W-1:0]  out_value;
  logic             out_empty, out_full;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_count <= CFG_W'(CFG_RESET);
    end else if (cfg_we) begin
      queue_count <= cfg_wdata;
    end
  end

  mqfb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_kind     (kind_t'(s_tuser)),
    .in_category (s_tdata[CAT_W-1:0]),
    .in_post_id  (s_tdata[CAT_W+ID_W-1:CAT_W]),
    .queue_count (queue_count),
    .cmd_valid   (f_valid),
    .cmd_ready   (f_ready),
    .cmd         (f_cmd)
  );

  mqfb_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_cmd   (b_cmd)
  );

  mqfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd       (b_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (out_value),
    .out_empty (out_empty),
    .out_full  (out_full)
  );

  // Pack the result
  assign m_tdata = M_TDATA_W'(out_value);
  assign m_tuser = {out_full, out_empty};

endmodule

`default_nettype wire

/* rtl/mqfb_check.sv */
// ----------------------------------------------------------------------------
// mqfb_check: port-level checks for the multi-queue FIFO bank
// Watches the result channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module mqfb_check (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              m_tvalid,
  input  wire logic                              m_tready,
  input  wire logic [mqfb_pkg::M_TDATA_W-1:0]    m_tdata,
  input  wire logic [1:0]                        m_tuser
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A result is never both empty and full
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("empty and full flags both set");

  // Flagged results carry a zero value
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[0] || m_tuser[1])) |-> (m_tdata == '0))
    else $error("flagged result with nonzero value");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind multi_queue_fifo_bank mqfb_check u_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
